FILE: rtl/obt_pkg.sv
// Shared types, codes and constants for the obstacle box table.
package obt_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam int FIELD_BITS     = 16;
    localparam int IN_COORDS      = 9;
    localparam int S_TDATA_BITS   = IN_COORDS * FIELD_BITS;
    localparam int M_TDATA_BITS   = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = FIELD_BITS;

    localparam int MAP_LOW_RESET  = 0;
    localparam int MAP_HIGH_RESET = 255;
    localparam int MAP_MIN_BITS   = 9;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_LOW_X  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_LOW_Y  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_LOW_Z  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HIGH_X = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HIGH_Y = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HIGH_Z = 3'd5;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MISORDER  = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } obt_result_t;

endpackage

FILE: rtl/obstacle_box_table_core.sv
// Top level of the obstacle box table: map registers, sequencer and result register.
// Add: the item is checked, then its result is emitted into the output register.
// Query: the box memory is scanned at one entry per cycle until the first hit or the last stored box,
// then the result is emitted. The next item is taken once the output register accepts the result.
// Reset (aresetn low, synchronous): box count cleared, map bounds to 0 and 255, no result held;
// the box memory is not cleared.
module obstacle_box_table_core #(
    parameter int MAX_BOXES  = obt_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = obt_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
    // point_x, point_y, point_z
    input  logic [obt_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // func
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, hit
    output logic [obt_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [obt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [obt_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import obt_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int MB = (COORD_BITS > MAP_MIN_BITS) ? COORD_BITS : MAP_MIN_BITS;

    logic [3*MB-1:0]            map_low_reg, map_low_next;
    logic [3*MB-1:0]            map_high_reg, map_high_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0]    m_tdata_reg, m_tdata_next;

    logic [CB-1:0]              cfg_coord;
    logic [MB-1:0]              cfg_ext;
    logic                       res_valid;
    logic                       res_ready;
    obt_result_t                res;

    assign cfg_coord = CB'(cfg_wdata);
    assign cfg_ext   = MB'($signed(cfg_coord));

    always_comb begin
        map_low_next  = map_low_reg;
        map_high_next = map_high_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MAP_LOW_X:  map_low_next[0*MB +: MB]  = cfg_ext;
                REG_MAP_LOW_Y:  map_low_next[1*MB +: MB]  = cfg_ext;
                REG_MAP_LOW_Z:  map_low_next[2*MB +: MB]  = cfg_ext;
                REG_MAP_HIGH_X: map_high_next[0*MB +: MB] = cfg_ext;
                REG_MAP_HIGH_Y: map_high_next[1*MB +: MB] = cfg_ext;
                REG_MAP_HIGH_Z: map_high_next[2*MB +: MB] = cfg_ext;
                default: begin
                end
            endcase
        end
    end

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_BITS'({res.hit, res.status});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                map_low_reg[a*MB +: MB]  <= MB'(MAP_LOW_RESET);
                map_high_reg[a*MB +: MB] <= MB'(MAP_HIGH_RESET);
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            map_low_reg  <= map_low_next;
            map_high_reg <= map_high_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    obt_ctrl #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS),
        .MAP_BITS   (MB)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .map_low   (map_low_reg),
        .map_high  (map_high_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/obt_box_mem.sv
// Box corner memory: one write port, one read port, registered read data.
module obt_box_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] box_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            box_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= box_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/obt_ctrl.sv
// Item sequencer: add checks, box append and query scan over the box memory.
module obt_ctrl #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16,
    parameter int MAP_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [obt_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  logic                              s_tuser,
    input  logic [3*MAP_BITS-1:0]             map_low,
    input  logic [3*MAP_BITS-1:0]             map_high,
    output logic                              res_valid,
    input  logic                              res_ready,
    output obt_pkg::obt_result_t              res
);
    import obt_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int MB = MAP_BITS;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int WW = 6 * CB;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               func_reg, func_next;
    logic [9*CB-1:0]    item_reg, item_next;
    obt_result_t        result_reg, result_next;

    logic [9*CB-1:0]    item_conv;
    logic               mem_we;
    logic               rd_en;
    logic [WW-1:0]      rd_data;
    logic               ordered;
    logic               in_map;
    logic               box_hit;
    logic               match;
    logic [1:0]         add_status;

    always_comb begin
        for (int g = 0; g < IN_COORDS; g++) begin
            item_conv[g*CB +: CB] = CB'(s_tdata[g*FIELD_BITS +: FIELD_BITS]);
        end
    end

    always_comb begin
        logic signed [MB-1:0] lo_e;
        logic signed [MB-1:0] hi_e;
        logic signed [MB-1:0] ml;
        logic signed [MB-1:0] mh;
        ordered = 1'b1;
        in_map  = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo_e = MB'($signed(item_reg[a*CB +: CB]));
            hi_e = MB'($signed(item_reg[(3+a)*CB +: CB]));
            ml   = $signed(map_low[a*MB +: MB]);
            mh   = $signed(map_high[a*MB +: MB]);
            if (!($signed(item_reg[a*CB +: CB]) < $signed(item_reg[(3+a)*CB +: CB]))) begin
                ordered = 1'b0;
            end
            if (!(ml <= lo_e && lo_e < mh && ml <= hi_e && hi_e < mh)) begin
                in_map = 1'b0;
            end
        end
    end

    always_comb begin
        priority if (!ordered) begin
            add_status = STATUS_MISORDER;
        end else if (!in_map) begin
            add_status = STATUS_OUTSIDE;
        end else if (count_reg >= CW'(MAX_BOXES)) begin
            add_status = STATUS_FULL;
        end else begin
            add_status = STATUS_OK;
        end
    end

    always_comb begin
        logic signed [CB-1:0] lo;
        logic signed [CB-1:0] hi;
        logic signed [CB-1:0] p;
        box_hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo = $signed(rd_data[a*CB +: CB]);
            hi = $signed(rd_data[(3+a)*CB +: CB]);
            p  = $signed(item_reg[(6+a)*CB +: CB]);
            if (!(lo <= p && p < hi)) begin
                box_hit = 1'b0;
            end
        end
    end

    assign match = rd_pend_reg && box_hit;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        rd_pend_next = rd_pend_reg;
        func_next    = func_reg;
        item_next    = item_reg;
        result_next  = result_reg;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        res_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    item_next  = item_conv;
                    func_next  = s_tuser;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (func_reg == FUNC_ADD) begin
                    result_next.status = add_status;
                    result_next.hit    = 1'b0;
                    if (add_status == STATUS_OK) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end else begin
                    rd_idx_next  = '0;
                    rd_pend_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en        = !match && (rd_idx_reg < count_reg);
                rd_pend_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (match || (!rd_en && !rd_pend_reg)) begin
                    result_next.status = STATUS_OK;
                    result_next.hit    = match;
                    rd_pend_next       = 1'b0;
                    state_next         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
        end
        rd_idx_reg <= rd_idx_next;
        func_reg   <= func_next;
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    obt_box_mem #(
        .DEPTH (MAX_BOXES),
        .WIDTH (WW),
        .AW    (AW)
    ) u_box_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item_reg[WW-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign res      = result_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_BOXES))
        else $error("box count above table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("box count moved by other than one");

    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("box write without count advance");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule
